// File: hdl/reflective_flow_table_with_aging_core_defines.svh
// ----------------------------------------------------------------------------
// reflective_flow_table_with_aging_core_defines
// assertion macros shared by the flow table modules
// ----------------------------------------------------------------------------
`ifndef REFLECTIVE_FLOW_TABLE_WITH_AGING_CORE_DEFINES_SVH
`define REFLECTIVE_FLOW_TABLE_WITH_AGING_CORE_DEFINES_SVH

// a condition must imply a consequence in the same cycle
`define RFT_ASSERT_IMP(lbl, clk_s, rst_s, cond, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (cond) |-> (cons)) \
    else $error(msg);

// a condition must imply a consequence in the next cycle
`define RFT_ASSERT_NEXT(lbl, clk_s, rst_s, cond, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (cond) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rft_pkg.sv
// ----------------------------------------------------------------------------
// rft_pkg
// shared types, codes and defaults of the flow table
// ----------------------------------------------------------------------------
`default_nettype none
package rft_pkg;
  localparam int unsigned TableEntriesDef = 64;
  localparam int unsigned TimeBitsDef     = 32;
  localparam int unsigned TimeoutBits     = 31;
  localparam int unsigned IntervalBits    = 16;
  localparam int unsigned CountBits       = 7;
  localparam int unsigned QfiBits         = 6;
  localparam int unsigned KeyBits         = 104;
  localparam logic [TimeoutBits-1:0]  TimeoutReset  = 31'd1000;
  localparam logic [IntervalBits-1:0] IntervalReset = 16'd100;
  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;

  typedef enum logic [1:0] {
    OP_LEARN  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    REG_TIMEOUT  = 1'b0,
    REG_INTERVAL = 1'b1
  } reg_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input beat
    logic scan_start; // clear scan index and hit flags
    logic scan_step;  // examine next entry for match / free slot
    logic apply;      // learn/lookup decision and write
    logic sweep_start;
    logic sweep_step;
    logic tick;       // advance time and countdown
    logic out_load;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic sweep_done;
    logic sweep_due;
  } sts_t;
endpackage
`default_nettype wire

// File: hdl/rft_ram.sv
// ----------------------------------------------------------------------------
// rft_ram
// generic single-port-write, single-read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module rft_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hdl/rft_datapath.sv
// ----------------------------------------------------------------------------
// rft_datapath
// key store, valid bits, time base, scan and sweep counters, result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "reflective_flow_table_with_aging_core_defines.svh"
module rft_datapath #(
  parameter int unsigned TABLE_ENTRIES = rft_pkg::TableEntriesDef,
  parameter int unsigned TIME_BITS     = rft_pkg::TimeBitsDef
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire rft_pkg::ctl_t                     ctl,
  output rft_pkg::sts_t                          sts,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_idx,
  input  wire logic [rft_pkg::TimeoutBits-1:0]   cfg_data,
  input  wire logic [1:0]                        op_i,
  input  wire logic                              kv_i,
  input  wire logic [31:0]                       sa_i,
  input  wire logic [31:0]                       da_i,
  input  wire logic [7:0]                        pr_i,
  input  wire logic [15:0]                       sp_i,
  input  wire logic [15:0]                       dp_i,
  input  wire logic [5:0]                        qfi_i,
  output logic [55:0]                            res_o
);
  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned KB = rft_pkg::KeyBits;

  logic [rft_pkg::TimeoutBits-1:0]  timeout_r;
  logic [rft_pkg::IntervalBits-1:0] interval_r, countdown_r;
  logic [TIME_BITS-1:0]             now_r;
  logic [CW-1:0]                    occ_r, removed_r;
  logic [TABLE_ENTRIES-1:0]         valid_r, active_r;
  logic [1:0]                       op_r;
  logic                             kv_r;
  logic [KB-1:0]                    key_r;
  logic [5:0]                       qfi_r;
  logic [IW:0]                      idx_r;
  logic [IW-1:0]                    ridx_r;
  logic                             rvld_r;
  logic                             hit_r, free_r;
  logic [IW-1:0]                    hit_idx_r, free_idx_r;
  logic [5:0]                       found_r;
  logic                             matched_r, expired_r, created_r, dropped_r;

  // key and stamp stores, read at the scan index
  logic [KB-1:0]        key_rd;
  logic [5:0]           qfi_rd;
  logic [TIME_BITS-1:0] ts_rd;
  logic                 key_we, ts_we;
  logic [IW-1:0]        waddr;
  logic [IW-1:0]        raddr;
  logic [15:0]          sp_m, dp_m;
  logic                 keep_ports;
  logic [TIME_BITS-1:0] age;
  logic                 stale;
  logic                 scan_end;

  assign keep_ports = (pr_i == rft_pkg::ProtoTcp) || (pr_i == rft_pkg::ProtoUdp);
  assign sp_m       = keep_ports ? sp_i : 16'd0;
  assign dp_m       = keep_ports ? dp_i : 16'd0;
  assign raddr      = idx_r[IW-1:0];
  assign age        = now_r - ts_rd;
  assign stale      = {{rft_pkg::TimeoutBits{1'b0}}, age} > {{TIME_BITS{1'b0}}, timeout_r};
  assign scan_end   = (idx_r == (IW+1)'(TABLE_ENTRIES)) && !rvld_r;

  rft_ram #(.WIDTH(KB + 6), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(waddr), .wdata({qfi_r, key_r}),
    .raddr(raddr), .rdata({qfi_rd, key_rd})
  );
  rft_ram #(.WIDTH(TIME_BITS), .DEPTH(TABLE_ENTRIES)) u_ts_ram (
    .clk(clk), .we(ts_we), .waddr(waddr), .wdata(now_r),
    .raddr(raddr), .rdata(ts_rd)
  );

  // write decisions taken in the apply step of a learn
  logic learn_go;
  assign learn_go = ctl.apply && (op_r == rft_pkg::OP_LEARN) && kv_r;
  assign key_we   = learn_go && !hit_r && free_r;
  assign ts_we    = learn_go && (hit_r || free_r);
  assign waddr    = hit_r ? hit_idx_r : free_idx_r;

  assign sts.scan_done  = ctl.scan_step && scan_end;
  assign sts.sweep_done = ctl.sweep_step && scan_end;
  assign sts.sweep_due  = countdown_r <= 16'd1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= rft_pkg::TimeoutReset;
      interval_r <= rft_pkg::IntervalReset;
    end else if (cfg_we) begin
      case (cfg_idx)
        rft_pkg::REG_TIMEOUT:  timeout_r  <= cfg_data;
        rft_pkg::REG_INTERVAL: interval_r <= cfg_data[rft_pkg::IntervalBits-1:0];
        default: ;
      endcase
    end
  end

  // item capture with reversed key for learns
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_r  <= op_i;
      kv_r  <= kv_i;
      qfi_r <= qfi_i;
      if (op_i == rft_pkg::OP_LEARN) begin
        key_r <= {da_i, sa_i, pr_i, dp_m, sp_m};
      end else begin
        key_r <= {sa_i, da_i, pr_i, sp_m, dp_m};
      end
    end
  end

  // scan index: address issued at idx, data examined in the next cycle at ridx
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      rvld_r <= 1'b0;
    end else if (ctl.scan_start || ctl.sweep_start) begin
      idx_r  <= '0;
      rvld_r <= 1'b0;
    end else if (ctl.scan_step || ctl.sweep_step) begin
      rvld_r <= 1'b0;
      if (idx_r != (IW+1)'(TABLE_ENTRIES)) begin
        idx_r  <= idx_r + 1'b1;
        rvld_r <= 1'b1;
        ridx_r <= idx_r[IW-1:0];
      end
    end
  end

  // match and free-slot search
  always_ff @(posedge clk) begin
    if (ctl.scan_start) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (ctl.scan_step && rvld_r) begin
      if (valid_r[ridx_r] && key_rd == key_r && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= ridx_r;
        found_r   <= qfi_rd;
      end
      if (!valid_r[ridx_r] && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= ridx_r;
      end
    end
  end

  // lookup staleness: matched entry stamp captured during the scan in hit_ts_r
  logic [TIME_BITS-1:0] hit_ts_r;
  always_ff @(posedge clk) begin
    if (ctl.scan_step && rvld_r && valid_r[ridx_r] && key_rd == key_r && !hit_r) begin
      hit_ts_r <= ts_rd;
    end
  end
  logic [TIME_BITS-1:0] hit_age;
  logic                 hit_stale;
  assign hit_age   = now_r - hit_ts_r;
  assign hit_stale = {{rft_pkg::TimeoutBits{1'b0}}, hit_age} >
                     {{TIME_BITS{1'b0}}, timeout_r};

  // valid/active bits, occupancy, time and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      active_r    <= '0;
      occ_r       <= '0;
      removed_r   <= '0;
      now_r       <= '0;
      countdown_r <= rft_pkg::IntervalReset;
      matched_r   <= 1'b0;
      expired_r   <= 1'b0;
      created_r   <= 1'b0;
      dropped_r   <= 1'b0;
    end else begin
      if (ctl.load) begin
        removed_r <= '0;
        matched_r <= 1'b0;
        expired_r <= 1'b0;
        created_r <= 1'b0;
        dropped_r <= 1'b0;
      end
      if (ctl.tick) begin
        now_r <= now_r + 1'b1;
        if (countdown_r <= 16'd1) begin
          countdown_r <= interval_r;
        end else begin
          countdown_r <= countdown_r - 1'b1;
        end
      end
      if (learn_go) begin
        if (hit_r) begin
          active_r[hit_idx_r] <= 1'b1;
        end else if (free_r) begin
          valid_r[free_idx_r]  <= 1'b1;
          active_r[free_idx_r] <= 1'b1;
          occ_r                <= occ_r + 1'b1;
          created_r            <= 1'b1;
        end else begin
          dropped_r <= 1'b1;
        end
      end
      if (ctl.apply && op_r == rft_pkg::OP_LOOKUP && kv_r && hit_r && active_r[hit_idx_r]) begin
        if (hit_stale) begin
          active_r[hit_idx_r] <= 1'b0;
          expired_r           <= 1'b1;
        end else begin
          matched_r <= 1'b1;
        end
      end
      if (ctl.sweep_step && rvld_r && valid_r[ridx_r] && stale) begin
        valid_r[ridx_r] <= 1'b0;
        occ_r           <= occ_r - 1'b1;
        removed_r       <= removed_r + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      res_o <= {32'd0,
                7'(occ_r), 7'(removed_r), dropped_r, created_r, expired_r,
                matched_r, (matched_r ? found_r : 6'd0)};
    end
  end

  `RFT_ASSERT_IMP(a_occ_range, clk, rst_n, 1'b1, occ_r <= CW'(TABLE_ENTRIES), "occupancy overflow")
  `RFT_ASSERT_IMP(a_one_flag, clk, rst_n, ctl.out_load, !(matched_r && expired_r), "match and expiry together")
  `RFT_ASSERT_NEXT(a_create_occ, clk, rst_n, key_we, occ_r == $past(occ_r) + 1'b1, "create did not count")
endmodule
`default_nettype wire

// File: hdl/rft_ctrl.sv
// ----------------------------------------------------------------------------
// rft_ctrl
// sequencer: capture, tick, scan, apply, sweep, deliver
// ----------------------------------------------------------------------------
`default_nettype none
`include "reflective_flow_table_with_aging_core_defines.svh"
module rft_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_fire,
  input  wire logic [1:0]    op_i,
  input  wire logic          kv_i,
  input  wire logic          out_busy,
  input  wire logic          out_fire,
  input  wire rft_pkg::sts_t sts,
  output rft_pkg::ctl_t      ctl,
  output logic               in_ready,
  output logic               out_set
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_APPLY = 7'b0001000,
    S_SWST  = 7'b0010000,
    S_SWEEP = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] op_r;
  logic       kv_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= op_i;
      kv_r <= kv_i;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    out_set   = 1'b0;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ctl.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (op_r == rft_pkg::OP_TICK) begin
          ctl.tick  = 1'b1;
          state_nxt = sts.sweep_due ? S_SWST : S_DONE;
        end else if (kv_r && (op_r == rft_pkg::OP_LEARN || op_r == rft_pkg::OP_LOOKUP)) begin
          ctl.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        ctl.apply = 1'b1;
        state_nxt = (op_r == rft_pkg::OP_LEARN) ? S_SWST : S_DONE;
      end
      S_SWST: begin
        ctl.sweep_start = 1'b1;
        state_nxt       = S_SWEEP;
      end
      S_SWEEP: begin
        ctl.sweep_step = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_busy || out_fire) begin
          ctl.out_load = 1'b1;
          out_set      = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `RFT_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, state_r == S_IDLE, "ready outside idle")
  `RFT_ASSERT_NEXT(a_fire_start, clk, rst_n, in_fire, state_r == S_START, "accept did not start")
  `RFT_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_r), "state not one-hot")
endmodule
`default_nettype wire

// File: hdl/reflective_flow_table_with_aging_core.sv
// ----------------------------------------------------------------------------
// reflective_flow_table_with_aging_core
// five-tuple flow table with reflective QFI learning and timed expiry
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low first)                          | tuser
// in      | in  | operation, key_valid, src_addr, dst_addr, protocol,| -
//         |     | src_port, dst_port, flow_qfi (pad to 120)         |
// out     | out | found_qfi, matched, expired_now, created,         | -
//         |     | full_drop, removed_count, entries_used (pad to 56)|
// cfg     | in  | index 0 timeout_ticks, 1 cleanup_interval         | -
//
// a lookup is paced by the one-entry-a-cycle key scan over all TABLE_ENTRIES slots;
// a learn adds a sweep pass over the table
// a tick advances time, and adds a sweep pass when the sweep countdown expires
// one item at a time; the next beat is taken once the result sits in the
// output register, which holds under out_tready low
// reset is synchronous; no clearing pass, valid bits are cleared at once
`default_nettype none
module reflective_flow_table_with_aging_core #(
  parameter int unsigned TABLE_ENTRIES = rft_pkg::TableEntriesDef,
  parameter int unsigned TIME_BITS     = rft_pkg::TimeBitsDef
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // operation, key_valid, src_addr, dst_addr, protocol, src_port, dst_port, flow_qfi
  input  wire logic [119:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // found_qfi, matched, expired_now, created, full_drop, removed_count, entries_used
  output logic [55:0]       out_tdata,
  input  wire logic         cfg_we,
  input  wire logic         cfg_idx,
  input  wire logic [30:0]  cfg_data
);
  rft_pkg::ctl_t ctl;
  rft_pkg::sts_t sts;
  logic in_fire, out_fire, out_set, out_valid_r;

  assign in_fire    = in_tvalid && in_tready;
  assign out_fire   = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;

  // output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_set) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  rft_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .op_i(in_tdata[1:0]),
    .kv_i(in_tdata[2]), .out_busy(out_valid_r), .out_fire(out_fire),
    .sts(sts), .ctl(ctl), .in_ready(in_tready), .out_set(out_set)
  );

  rft_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .TIME_BITS(TIME_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .op_i(in_tdata[1:0]), .kv_i(in_tdata[2]), .sa_i(in_tdata[34:3]),
    .da_i(in_tdata[66:35]), .pr_i(in_tdata[74:67]), .sp_i(in_tdata[90:75]),
    .dp_i(in_tdata[106:91]), .qfi_i(in_tdata[112:107]), .res_o(out_tdata)
  );
endmodule
`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// flow table bench: learn, lookup and tick beats against an internal predictor
// of the table, with random idling on both channels and register changes
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb;
  localparam int unsigned Slots = 64;

  typedef struct packed {
    logic [6:0]  used;
    logic [6:0]  swept;
    logic        dropped;
    logic        fresh;
    logic        stale;
    logic        hit;
    logic [5:0]  qfi;
  } verdict_t;

  logic          clk;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [119:0]  in_tdata;
  logic          out_tvalid;
  logic          out_tready;
  logic [55:0]   out_tdata;
  logic          cfg_we;
  logic          cfg_idx;
  logic [30:0]   cfg_data;

  // predictor state
  logic          t_valid [Slots];
  logic [31:0]   t_sa [Slots];
  logic [31:0]   t_da [Slots];
  logic [7:0]    t_pr [Slots];
  logic [31:0]   t_ports [Slots];
  logic [5:0]    t_qfi [Slots];
  logic [31:0]   t_seen [Slots];
  logic          t_act [Slots];
  logic [31:0]   now_ticks;
  logic [15:0]   countdown;
  int unsigned   fill;
  logic [30:0]   age_limit;
  logic [15:0]   reload;

  verdict_t      pending_q[$];
  int            errors;
  int            beats_sent;
  int            beats_seen;
  bit            quiet;
  int            tx_gap;

  // key pool, so lookups and relearns hit
  logic [31:0]   pool_a [16];
  logic [31:0]   pool_b [16];
  logic [7:0]    pool_p [16];
  logic [15:0]   pool_s [16];
  logic [15:0]   pool_d [16];

  reflective_flow_table_with_aging_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // timeout guard
  initial begin
    #60ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic is_old(int i);
    logic [31:0] age;
    age = now_ticks - t_seen[i];
    return age > {1'b0, age_limit};
  endfunction

  function automatic logic [6:0] run_sweep();
    int n;
    n = 0;
    for (int i = 0; i < Slots; i++) begin
      if (t_valid[i] && is_old(i)) begin
        t_valid[i] = 1'b0;
        n++;
      end
    end
    fill -= n;
    return n[6:0];
  endfunction

  function automatic int find_key(logic [31:0] a, logic [31:0] b, logic [7:0] p,
                                  logic [31:0] ports);
    for (int i = 0; i < Slots; i++)
      if (t_valid[i] && t_sa[i] == a && t_da[i] == b && t_pr[i] == p &&
          t_ports[i] == ports)
        return i;
    return -1;
  endfunction

  // work out the result of one beat and advance the table copy
  function automatic verdict_t flow_table_predict(rft_pkg::op_t op, logic kv,
                                                  logic [31:0] sa,
                                                  logic [31:0] da, logic [7:0] pr,
                                                  logic [15:0] sp, logic [15:0] dp,
                                                  logic [5:0] q);
    verdict_t v;
    int s;
    logic [31:0] ports;
    v = '0;
    if (pr != rft_pkg::ProtoTcp && pr != rft_pkg::ProtoUdp) begin
      sp = '0;
      dp = '0;
    end
    if (op == rft_pkg::OP_LEARN && kv) begin
      ports = {dp, sp};
      s = find_key(da, sa, pr, ports);
      if (s >= 0) begin
        t_seen[s] = now_ticks;
        t_act[s] = 1'b1;
      end else if (fill < Slots) begin
        for (int i = 0; i < Slots; i++) begin
          if (!t_valid[i]) begin
            t_valid[i] = 1'b1;
            t_sa[i] = da;
            t_da[i] = sa;
            t_pr[i] = pr;
            t_ports[i] = ports;
            t_qfi[i] = q;
            t_seen[i] = now_ticks;
            t_act[i] = 1'b1;
            fill++;
            v.fresh = 1'b1;
            break;
          end
        end
      end else begin
        v.dropped = 1'b1;
      end
      v.swept = run_sweep();
    end else if (op == rft_pkg::OP_LOOKUP && kv) begin
      s = find_key(sa, da, pr, {sp, dp});
      if (s >= 0 && t_act[s]) begin
        if (!is_old(s)) begin
          v.qfi = t_qfi[s];
          v.hit = 1'b1;
        end else begin
          t_act[s] = 1'b0;
          v.stale = 1'b1;
        end
      end
    end else if (op == rft_pkg::OP_TICK) begin
      now_ticks = now_ticks + 32'd1;
      if (countdown <= 16'd1) begin
        v.swept = run_sweep();
        countdown = reload;
      end else begin
        countdown = countdown - 16'd1;
      end
    end
    v.used = fill[6:0];
    return v;
  endfunction

  // random idle burst, none in the quiet tail
  task automatic idle_burst();
    if (!quiet && $urandom_range(3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
  endtask

  // valid stays high after the accepting edge until the next beat or a drain
  task automatic send_beat(rft_pkg::op_t op, logic kv, logic [31:0] sa, logic [31:0] da,
                           logic [7:0] pr, logic [15:0] sp, logic [15:0] dp,
                           logic [5:0] q);
    idle_burst();
    pending_q.push_back(flow_table_predict(op, kv, sa, da, pr, sp, dp, q));
    in_tdata  <= {7'd0, q, dp, sp, pr, da, sa, kv, op};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic tick_n(int n);
    for (int i = 0; i < n; i++)
      send_beat(rft_pkg::OP_TICK, 1'($urandom_range(1)), $urandom, $urandom,
                8'($urandom), 16'($urandom), 16'($urandom), 6'($urandom));
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(rft_pkg::reg_t idx, logic [30:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    if (idx == rft_pkg::REG_TIMEOUT) age_limit = val;
    else reload = val[15:0];
    @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    verdict_t got;
    verdict_t exp_v;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[23:0];
      beats_seen++;
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result %h", $realtime, got);
        errors++;
      end else begin
        exp_v = pending_q.pop_front();
        if (got !== exp_v || out_tdata[55:24] !== '0) begin
          $display("%0t result mismatch: expected %h actual %h", $realtime, exp_v,
                   out_tdata);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(16, 1)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(20)) @(posedge clk);
    end
  end

  task automatic test_directed();
    // missing key, unused operation, port zeroing, field extremes
    send_beat(rft_pkg::OP_LEARN, 1'b0, '1, '1, rft_pkg::ProtoTcp, '1, '1, '1);
    send_beat(rft_pkg::OP_LOOKUP, 1'b0, '1, '1, rft_pkg::ProtoTcp, '1, '1, '1);
    send_beat(rft_pkg::OP_NONE, 1'b1, '1, '1, '1, '1, '1, '1);
    send_beat(rft_pkg::OP_LEARN, 1'b1, 32'h0a000001, 32'h0a000002, rft_pkg::ProtoTcp,
              16'hffff, 16'h0, 6'h3f);
    send_beat(rft_pkg::OP_LOOKUP, 1'b1, 32'h0a000002, 32'h0a000001, rft_pkg::ProtoTcp,
              16'h0, 16'hffff, 6'h0);
    send_beat(rft_pkg::OP_LEARN, 1'b1, '0, '0, 8'hff, 16'h1234, 16'h5678, 6'h21);
    send_beat(rft_pkg::OP_LOOKUP, 1'b1, '0, '0, 8'hff, 16'h9999, 16'h1, 6'h0);
    send_beat(rft_pkg::OP_LEARN, 1'b1, '1, '1, rft_pkg::ProtoUdp, 16'h1, 16'h2, 6'h0);
    // relearn keeps qfi
    send_beat(rft_pkg::OP_LEARN, 1'b1, '1, '1, rft_pkg::ProtoUdp, 16'h1, 16'h2, 6'h15);
    send_beat(rft_pkg::OP_LOOKUP, 1'b1, '1, '1, rft_pkg::ProtoUdp, 16'h2, 16'h1, 6'h0);
  endtask

  task automatic test_expiry();
    // short timeout: sweep removal, then hit, stale lookup and inactive hit
    drain();
    write_reg(rft_pkg::REG_TIMEOUT, 31'd2);
    write_reg(rft_pkg::REG_INTERVAL, 31'd0);
    send_beat(rft_pkg::OP_LEARN, 1'b1, 32'h1, 32'h2, rft_pkg::ProtoUdp, 16'h10, 16'h20,
              6'h7);
    tick_n(3);
    drain();
    write_reg(rft_pkg::REG_INTERVAL, 31'd50);
    write_reg(rft_pkg::REG_TIMEOUT, 31'd0);
    send_beat(rft_pkg::OP_LEARN, 1'b1, 32'h5, 32'h6, 8'd1, 16'h0, 16'h0, 6'h9);
    send_beat(rft_pkg::OP_LOOKUP, 1'b1, 32'h6, 32'h5, 8'd1, 16'h0, 16'h0, 6'h0);
    tick_n(1);
    send_beat(rft_pkg::OP_LOOKUP, 1'b1, 32'h6, 32'h5, 8'd1, 16'h0, 16'h0, 6'h0);
    send_beat(rft_pkg::OP_LOOKUP, 1'b1, 32'h6, 32'h5, 8'd1, 16'h0, 16'h0, 6'h0);
  endtask

  task automatic test_full_table();
    // fill all slots; the last three learns get dropped, one slot still held from the expiry test
    drain();
    write_reg(rft_pkg::REG_TIMEOUT, 31'h7fffffff);
    for (int i = 0; i < Slots + 2; i++)
      send_beat(rft_pkg::OP_LEARN, 1'b1, 32'hc0a80000 + i, 32'h08080808,
                rft_pkg::ProtoTcp, 16'(i), 16'd80, i[5:0]);
    send_beat(rft_pkg::OP_LOOKUP, 1'b1, 32'h08080808, 32'hc0a80005, rft_pkg::ProtoTcp,
              16'd80, 16'd5, 6'h0);
  endtask

  task automatic random_phase(int n, logic [30:0] tmo, logic [15:0] ivl);
    int k;
    logic [7:0] pr;
    drain();
    write_reg(rft_pkg::REG_TIMEOUT, tmo);
    write_reg(rft_pkg::REG_INTERVAL, {15'd0, ivl});
    for (int i = 0; i < 16; i++) begin
      pool_a[i] = $urandom;
      pool_b[i] = $urandom;
      pool_p[i] = ($urandom_range(2) == 0) ? rft_pkg::ProtoUdp :
                  ($urandom_range(1) ? rft_pkg::ProtoTcp : 8'($urandom));
      pool_s[i] = 16'($urandom);
      pool_d[i] = 16'($urandom);
    end
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(15);
      case ($urandom_range(9))
        0, 1, 2: send_beat(rft_pkg::OP_LEARN, 1'b1, pool_a[k], pool_b[k], pool_p[k],
                           pool_s[k], pool_d[k], 6'($urandom));
        3, 4, 5: send_beat(rft_pkg::OP_LOOKUP, 1'b1, pool_b[k], pool_a[k], pool_p[k],
                           pool_d[k], pool_s[k], 6'($urandom));
        6, 7: tick_n($urandom_range(8, 1));
        default: begin
          pr = 8'($urandom);
          send_beat(rft_pkg::op_t'(2'($urandom_range(3))), 1'($urandom_range(1)),
                    $urandom, $urandom, pr, 16'($urandom), 16'($urandom),
                    6'($urandom));
        end
      endcase
    end
  endtask

  initial begin
    errors = 0;
    beats_sent = 0;
    beats_seen = 0;
    quiet = 1'b0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= rft_pkg::REG_TIMEOUT;
    cfg_data <= '0;
    for (int i = 0; i < Slots; i++) begin
      t_valid[i] = 1'b0;
      t_act[i] = 1'b0;
    end
    now_ticks = '0;
    countdown = rft_pkg::IntervalReset;
    reload = rft_pkg::IntervalReset;
    age_limit = rft_pkg::TimeoutReset;
    fill = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_expiry();
    test_full_table();
    random_phase(200, 31'd20, 16'd1);
    random_phase(200, 31'd1000, 16'd65535);
    random_phase(150, 31'd5, 16'd3);
    quiet = 1'b1;
    random_phase(150, 31'd40, 16'd7);
    drain();

    $display("covered %0d input beats and %0d results over learn, lookup, tick,",
             beats_sent, beats_seen);
    $display("expiry, full-table drop and several timeout and interval settings");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: reflective_flow_table_with_aging_core.f
+incdir+hdl
hdl/rft_pkg.sv
hdl/rft_ram.sv
hdl/rft_datapath.sv
hdl/rft_ctrl.sv
hdl/reflective_flow_table_with_aging_core.sv
verif/tb.sv
